// ----- design/tcw_pkg.sv -----
package tcw_pkg;

   localparam int SCREEN_COLUMNS = 80;
   localparam int SCREEN_LINES   = 25;
   localparam int TAB_STOP       = 8;

   localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_LINES;
   localparam int COPY_COUNT = SCREEN_COLUMNS * (SCREEN_LINES - 1);
   localparam int LAST_COL   = SCREEN_COLUMNS - 1;
   localparam int LAST_ROW   = SCREEN_LINES - 1;

   // field widths
   localparam int COL_W     = 7;
   localparam int ROW_W     = 5;
   localparam int CADDR_W   = 11;
   localparam int BYTE_W    = 8;
   localparam int NIB_W     = 4;
   localparam int OP_W      = 2;
   localparam int CELL_W    = 2 * BYTE_W;
   localparam int CSR_IDX_W = 1;

   // memory and counter widths
   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int CNT_W  = $clog2(CELL_COUNT + 1);
   localparam int PROD_W = ROW_W + COL_W + 1;

   // opcodes
   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_SET   = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

   // control characters
   localparam logic [BYTE_W-1:0] CH_BS    = 8'd8;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
   localparam logic [BYTE_W-1:0] CH_BLANK = 8'h20;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ERASE_ATTR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_ATTR  = 1'd1;

   localparam logic [BYTE_W-1:0] ERASE_ATTR_RST = 8'd7;
   localparam logic [BYTE_W-1:0] FILL_ATTR_RST  = 8'd15;

   typedef logic [CELL_W-1:0] cell_type;

   function automatic logic [PROD_W-1:0] lin_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
      lin_addr = PROD_W'(row) * PROD_W'(SCREEN_COLUMNS) + PROD_W'(col);
   endfunction

endpackage

// ----- design/text_console_writer.sv -----
// Text console engine: a screen of character cells plus a cursor.
// Command channel: start/busy. A command is taken when start is high and busy
// is low; the req_ fields must be valid in that cycle. Opcodes are put
// character, read cell, set cursor and clear screen.
// Result channel: rsp_valid is high for exactly one cycle per command, with
// the cursor after the command and, for read cell, the cell contents. The
// receiver cannot stall; busy stays high until the result cycle has passed.
// Register port: csr_valid/csr_ready with csr_index and csr_data; csr_ready is
// always high, so a write lands in the cycle it is offered.
// Plain character, carriage return, backspace and set cursor go straight to
// the result; read cell first waits for the memory read; newline and tab
// first blank up to 80 cells, one per cycle. A line wrap on the last line
// adds a scroll, and clear screen writes every cell. busy drops after the
// result cycle. The cell memory has 2000 entries and a single write port,
// which takes one cell per cycle.
// After reset a clearing pass fills every cell with a blank in attribute 15;
// busy is high during it, and register writes are taken.
module text_console_writer
   import tcw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [OP_W-1:0]      req_opcode,
   input  logic [BYTE_W-1:0]    req_char_code,
   input  logic [NIB_W-1:0]     req_fg_colour,
   input  logic [NIB_W-1:0]     req_bg_colour,
   input  logic [ROW_W-1:0]     req_target_row,
   input  logic [COL_W-1:0]     req_target_col,
   output logic                 rsp_valid,
   output logic [COL_W-1:0]     rsp_cursor_column,
   output logic [ROW_W-1:0]     rsp_cursor_line,
   output logic [CADDR_W-1:0]   rsp_cursor_address,
   output logic [BYTE_W-1:0]    rsp_read_char,
   output logic [BYTE_W-1:0]    rsp_read_attr,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RESP   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_FILL   = 3'd3;
   localparam logic [2:0] S_CLEAR  = 3'd4;
   localparam logic [2:0] S_SCROLL = 3'd5;

   cell_type cell_mem [CELL_COUNT];

   logic [2:0]        state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [COL_W-1:0]  stop_ff, stop_in;
   logic [BYTE_W-1:0] attr_ff, attr_in;
   logic              from_op_ff, from_op_in;
   logic [BYTE_W-1:0] rchar_ff, rchar_in;
   logic [BYTE_W-1:0] rattr_ff, rattr_in;
   logic [BYTE_W-1:0] erase_attr_ff, fill_attr_ff;
   cell_type          rdata_ff;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   cell_type          mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;

   logic [PROD_W-1:0] cur_lin;
   logic [ADDR_W-1:0] cur_addr;
   logic [BYTE_W-1:0] req_attr;
   logic [ROW_W-1:0]  row_clamp;
   logic [COL_W-1:0]  col_clamp;
   logic [PROD_W-1:0] tgt_lin;
   logic [COL_W:0]    tab_end;
   logic [COL_W-1:0]  tab_last;
   logic [CNT_W:0]    scroll_src;
   logic              wrap_req;

   assign cur_lin   = lin_addr(row_ff, col_ff);
   assign cur_addr  = cur_lin[ADDR_W-1:0];
   assign req_attr  = {req_bg_colour, req_fg_colour};
   assign row_clamp = (req_target_row > ROW_W'(LAST_ROW)) ? ROW_W'(LAST_ROW) : req_target_row;
   assign col_clamp = (req_target_col > COL_W'(LAST_COL)) ? COL_W'(LAST_COL) : req_target_col;
   assign tgt_lin   = lin_addr(row_clamp, col_clamp);
   assign tab_end   = {1'b0, col_ff} + (COL_W+1)'(TAB_STOP)
                      - {1'b0, col_ff % COL_W'(TAB_STOP)};
   assign tab_last  = (tab_end > (COL_W+1)'(SCREEN_COLUMNS)) ? COL_W'(LAST_COL)
                      : COL_W'(tab_end - (COL_W+1)'(1));
   assign scroll_src = {1'b0, cnt_ff} + (CNT_W+1)'(SCREEN_COLUMNS);

   always_comb begin
      state_in   = state_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      cnt_in     = cnt_ff;
      stop_in    = stop_ff;
      attr_in    = attr_ff;
      from_op_in = from_op_ff;
      rchar_in   = rchar_ff;
      rattr_in   = rattr_ff;
      mem_we     = 1'b0;
      mem_waddr  = cur_addr;
      mem_wdata  = {attr_ff, CH_BLANK};
      mem_raddr  = cur_addr;
      wrap_req   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rchar_in = '0;
               rattr_in = '0;
               case (req_opcode)
                  OP_PUT: begin
                     case (req_char_code)
                        CH_CR: begin
                           col_in   = '0;
                           state_in = S_RESP;
                        end
                        CH_LF: begin
                           stop_in  = COL_W'(LAST_COL);
                           attr_in  = req_attr;
                           state_in = S_FILL;
                        end
                        CH_TAB: begin
                           stop_in  = tab_last;
                           attr_in  = req_attr;
                           state_in = S_FILL;
                        end
                        CH_BS: begin
                           state_in = S_RESP;
                           if (col_ff != '0 || row_ff != '0) begin
                              // the cell before the cursor is always one address back
                              mem_we    = 1'b1;
                              mem_waddr = cur_addr - ADDR_W'(1);
                              mem_wdata = {erase_attr_ff, CH_BLANK};
                              if (col_ff == '0) begin
                                 col_in = COL_W'(LAST_COL);
                                 row_in = row_ff - ROW_W'(1);
                              end else begin
                                 col_in = col_ff - COL_W'(1);
                              end
                           end
                        end
                        default: begin
                           mem_we    = 1'b1;
                           mem_wdata = {req_attr, req_char_code};
                           if (col_ff == COL_W'(LAST_COL)) begin
                              wrap_req = 1'b1;
                           end else begin
                              col_in   = col_ff + COL_W'(1);
                              state_in = S_RESP;
                           end
                        end
                     endcase
                  end
                  OP_READ: begin
                     mem_raddr = tgt_lin[ADDR_W-1:0];
                     state_in  = S_READ;
                  end
                  OP_SET: begin
                     row_in   = row_clamp;
                     col_in   = col_clamp;
                     state_in = S_RESP;
                  end
                  default: begin
                     cnt_in     = '0;
                     attr_in    = fill_attr_ff;
                     from_op_in = 1'b1;
                     state_in   = S_CLEAR;
                  end
               endcase
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         S_READ: begin
            rchar_in = rdata_ff[BYTE_W-1:0];
            rattr_in = rdata_ff[CELL_W-1:BYTE_W];
            state_in = S_RESP;
         end
         S_FILL: begin
            mem_we = 1'b1;
            if (col_ff == stop_ff) begin
               if (col_ff == COL_W'(LAST_COL)) begin
                  wrap_req = 1'b1;
               end else begin
                  col_in   = col_ff + COL_W'(1);
                  state_in = S_RESP;
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[ADDR_W-1:0];
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CELL_COUNT - 1)) begin
               state_in = from_op_ff ? S_RESP : S_IDLE;
            end
         end
         S_SCROLL: begin
            // read one line ahead, write the registered data back in the next cycle
            mem_raddr = (cnt_ff < CNT_W'(COPY_COUNT)) ? scroll_src[ADDR_W-1:0] : '0;
            mem_we    = (cnt_ff != '0);
            mem_waddr = ADDR_W'(cnt_ff - CNT_W'(1));
            mem_wdata = (cnt_ff <= CNT_W'(COPY_COUNT)) ? rdata_ff
                        : {fill_attr_ff, CH_BLANK};
            if (cnt_ff == CNT_W'(CELL_COUNT)) begin
               state_in = S_RESP;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (wrap_req) begin
         col_in = '0;
         if (row_ff < ROW_W'(LAST_ROW)) begin
            row_in   = row_ff + ROW_W'(1);
            state_in = S_RESP;
         end else begin
            cnt_in   = '0;
            state_in = S_SCROLL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         col_ff     <= '0;
         row_ff     <= '0;
         cnt_ff     <= '0;
         stop_ff    <= '0;
         attr_ff    <= FILL_ATTR_RST;
         from_op_ff <= 1'b0;
         rchar_ff   <= '0;
         rattr_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         cnt_ff     <= cnt_in;
         stop_ff    <= stop_in;
         attr_ff    <= attr_in;
         from_op_ff <= from_op_in;
         rchar_ff   <= rchar_in;
         rattr_ff   <= rattr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         erase_attr_ff <= ERASE_ATTR_RST;
         fill_attr_ff  <= FILL_ATTR_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ERASE_ATTR: erase_attr_ff <= csr_data;
            CSR_FILL_ATTR:  fill_attr_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= cell_mem[mem_raddr];
   end

   assign csr_ready          = 1'b1;
   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = (state_ff == S_RESP);
   assign rsp_cursor_column  = col_ff;
   assign rsp_cursor_line    = row_ff;
   assign rsp_cursor_address = cur_lin[CADDR_W-1:0];
   assign rsp_read_char      = rchar_ff;
   assign rsp_read_attr      = rattr_ff;

endmodule

// ----- design/tcw_checker.sv -----
module tcw_checker
   import tcw_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic [COL_W-1:0]     rsp_cursor_column,
   input logic [ROW_W-1:0]     rsp_cursor_line,
   input logic [CADDR_W-1:0]   rsp_cursor_address
);

   logic [PROD_W-1:0] rsp_lin;

   assign rsp_lin = lin_addr(rsp_cursor_line, rsp_cursor_column);

   // an accepted item keeps the block busy until its result
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepting an item");

   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside busy");

   a_rsp_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe longer than one cycle");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cursor_column <= COL_W'(LAST_COL)
                     && rsp_cursor_line <= ROW_W'(LAST_ROW)))
      else $error("cursor off screen");

   a_cursor_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cursor_address == rsp_lin[CADDR_W-1:0]))
      else $error("cursor address does not match line and column");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
